@@ rtl/irqc_pkg.sv @@
// Shared types and constants of the interrupt controller.
package irqc_pkg;

	typedef enum logic [2:0] {
		CMD_READ    = 3'd0,
		CMD_WRITE   = 3'd1,
		CMD_REQUEST = 3'd2,
		CMD_DELAYED = 3'd3,
		CMD_ACK     = 3'd4,
		CMD_TICK    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		WIDTH_BYTE = 2'd0,
		WIDTH_HALF = 2'd1,
		WIDTH_WORD = 2'd2
	} width_t;

	localparam logic [11:0] ADDR_ENABLE = 12'h200;
	localparam logic [11:0] ADDR_FLAGS  = 12'h202;
	localparam logic [11:0] ADDR_MASTER = 12'h208;

	localparam logic [13:0] ENABLE_MASK = 14'h3FFF;
	localparam int unsigned FIRE_DELAY  = 4;

	typedef struct packed {
		cmd_t         command;
		width_t       access_width;
		logic [11:0]  address;
		logic [31:0]  write_data;
		logic [15:0]  irq_mask;
	} item_t;

	typedef struct packed {
		logic [13:0]  enable;
		logic [15:0]  flags;
		logic         master;
		logic [15:0]  pending;
		logic         clear_valid;
		logic [15:0]  delayed_mask;
	} irq_state_t;

endpackage

@@ rtl/irq_controller_delayed_flags.sv @@
// Top level of the interrupt controller: input register, state and result registers.
// A transaction accepted into the input register passes the update logic into the state and result registers.
// Throughput: one transaction per cycle while the result is taken; the single-pass update sets it.
// The register state (enable, flags, master) is the result register and holds between results.
// Reset (arst_n low, asynchronous) clears the state, result and handshake registers and the line.
module irq_controller_delayed_flags #(
	parameter int unsigned TIME_BITS = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            command,
	input  logic [11:0]           address,
	input  logic [1:0]            access_width,
	input  logic [31:0]           write_data,
	input  logic [15:0]           irq_mask,
	input  logic [TIME_BITS-1:0]  time_now,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           read_data,
	output logic                  irq_line,
	output logic [13:0]           enable_bits,
	output logic [15:0]           flag_bits,
	output logic                  master_enable
);
	import irqc_pkg::*;

	item_t                item_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic                 valid_s1;

	irq_state_t           state_q;
	irq_state_t           state_nxt;
	logic [TIME_BITS-1:0] due_q;
	logic [TIME_BITS-1:0] due_nxt;
	logic [TIME_BITS-1:0] fire_q;
	logic [TIME_BITS-1:0] fire_nxt;
	logic [31:0]          read_data_q;
	logic [31:0]          read_data_nxt;
	logic                 out_valid_q;
	logic                 advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.command      <= cmd_t'(command);
			item_s1.access_width <= width_t'(access_width);
			item_s1.address      <= address;
			item_s1.write_data   <= write_data;
			item_s1.irq_mask     <= irq_mask;
			time_s1              <= time_now;
		end
	end

	irqc_update #(
		.TIME_BITS (TIME_BITS)
	) u_update (
		.item          (item_s1),
		.time_now      (time_s1),
		.state_cur     (state_q),
		.due_cur       (due_q),
		.fire_cur      (fire_q),
		.state_nxt     (state_nxt),
		.due_nxt       (due_nxt),
		.fire_nxt      (fire_nxt),
		.read_data_nxt (read_data_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			due_q       <= '0;
			fire_q      <= '0;
			read_data_q <= 32'h0000_0000;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				due_q       <= due_nxt;
				fire_q      <= fire_nxt;
				read_data_q <= read_data_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = read_data_q;
	assign enable_bits   = state_q.enable;
	assign flag_bits     = state_q.flags;
	assign master_enable = state_q.master;
	assign irq_line      = state_q.master && ((state_q.enable & state_q.flags[13:0]) != 14'h0000);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	a_read_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.command == CMD_READ) |=> $stable(state_q))
		else $error("read transaction changed register state");

	a_non_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.command != CMD_READ) |=> (read_data == 32'h0000_0000))
		else $error("non-read transaction returned read data");

	a_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.command == CMD_ACK) |=>
		((flag_bits & $past(item_s1.irq_mask)) == 16'h0000))
		else $error("acknowledged flags still set");

endmodule

@@ rtl/irqc_update.sv @@
// Next-state and read-data logic for one transaction of the interrupt controller.
module irqc_update #(
	parameter int unsigned TIME_BITS = 48
) (
	input  irqc_pkg::item_t       item,
	input  logic [TIME_BITS-1:0]  time_now,
	input  irqc_pkg::irq_state_t  state_cur,
	input  logic [TIME_BITS-1:0]  due_cur,
	input  logic [TIME_BITS-1:0]  fire_cur,
	output irqc_pkg::irq_state_t  state_nxt,
	output logic [TIME_BITS-1:0]  due_nxt,
	output logic [TIME_BITS-1:0]  fire_nxt,
	output logic [31:0]           read_data_nxt
);
	import irqc_pkg::*;

	// 13-bit address so that the word upper half never wraps into the map
	function automatic logic [15:0] half_read(input logic [12:0] a, input irq_state_t s);
		logic [15:0] r;
		r = 16'h0000;
		if (a == {1'b0, ADDR_ENABLE}) r = {2'b00, s.enable};
		else if (a == {1'b0, ADDR_FLAGS}) r = s.flags;
		else if (a == {1'b0, ADDR_MASTER}) r = {15'h0000, s.master};
		return r;
	endfunction

	logic [12:0]          addr_lo;
	logic [12:0]          addr_hi;
	logic [12:0]          addr_al;
	logic [15:0]          cur_al;
	logic [15:0]          cur_lo;
	logic [15:0]          cur_hi;
	logic [12:0]          wa [2];
	logic [15:0]          wv [2];
	logic [15:0]          wc [2];
	logic                 we [2];
	logic [TIME_BITS-1:0] fire_new;

	assign addr_lo  = {1'b0, item.address};
	assign addr_hi  = addr_lo + 13'd2;
	assign addr_al  = {1'b0, item.address[11:1], 1'b0};
	assign cur_al   = half_read(addr_al, state_cur);
	assign cur_lo   = half_read(addr_lo, state_cur);
	assign cur_hi   = half_read(addr_hi, state_cur);
	assign fire_new = time_now + TIME_BITS'(FIRE_DELAY);

	// write slots: byte and half use one, word uses two
	always_comb begin
		wa[0] = addr_lo;
		wa[1] = addr_hi;
		wv[0] = item.write_data[15:0];
		wv[1] = item.write_data[31:16];
		wc[0] = item.write_data[15:0];
		wc[1] = item.write_data[31:16];
		we[0] = 1'b1;
		we[1] = 1'b0;
		case (item.access_width)
			WIDTH_BYTE: begin
				wa[0] = addr_al;
				if (item.address[0]) begin
					wv[0] = {item.write_data[7:0], cur_al[7:0]};
					wc[0] = {item.write_data[7:0], 8'h00};
				end else begin
					wv[0] = {cur_al[15:8], item.write_data[7:0]};
					wc[0] = {8'h00, item.write_data[7:0]};
				end
			end
			WIDTH_HALF: begin
				we[1] = 1'b0;
			end
			default: begin
				we[1] = 1'b1;
			end
		endcase
	end

	always_comb begin
		state_nxt     = state_cur;
		due_nxt       = due_cur;
		fire_nxt      = fire_cur;
		read_data_nxt = 32'h0000_0000;
		case (item.command)
			CMD_READ: begin
				case (item.access_width)
					WIDTH_BYTE: read_data_nxt = {24'h000000,
						item.address[0] ? cur_al[15:8] : cur_al[7:0]};
					WIDTH_HALF: read_data_nxt = {16'h0000, cur_lo};
					default:    read_data_nxt = {cur_hi, cur_lo};
				endcase
			end
			CMD_WRITE: begin
				for (int i = 0; i < 2; i++) begin
					if (we[i]) begin
						if (wa[i] == {1'b0, ADDR_ENABLE}) begin
							state_nxt.enable = wv[i][13:0] & ENABLE_MASK;
						end else if (wa[i] == {1'b0, ADDR_FLAGS}) begin
							state_nxt.pending     = state_nxt.pending & ~wc[i];
							due_nxt               = time_now + TIME_BITS'(1);
							state_nxt.clear_valid = 1'b1;
						end else if (wa[i] == {1'b0, ADDR_MASTER}) begin
							state_nxt.master = wv[i][0];
						end
					end
				end
			end
			CMD_REQUEST: begin
				state_nxt.flags   = state_cur.flags | item.irq_mask;
				state_nxt.pending = state_nxt.flags;
			end
			CMD_DELAYED: begin
				if (state_cur.delayed_mask == 16'h0000 || fire_new < fire_cur) begin
					fire_nxt = fire_new;
				end
				state_nxt.delayed_mask = state_cur.delayed_mask | item.irq_mask;
			end
			CMD_ACK: begin
				state_nxt.flags   = state_cur.flags & ~item.irq_mask;
				state_nxt.pending = state_nxt.flags;
			end
			CMD_TICK: begin
				// delayed raise first, then the pending clear
				if (state_cur.delayed_mask != 16'h0000 && time_now >= fire_cur) begin
					state_nxt.flags        = state_cur.flags | state_cur.delayed_mask;
					state_nxt.pending      = state_nxt.flags;
					state_nxt.delayed_mask = 16'h0000;
					fire_nxt               = '0;
				end
				if (state_cur.clear_valid && time_now >= due_cur) begin
					state_nxt.flags       = state_nxt.pending;
					state_nxt.clear_valid = 1'b0;
					due_nxt               = '0;
				end
			end
			default: begin
				state_nxt = state_cur;
			end
		endcase
	end

endmodule
